/* hw/rtl/skt_pkg.sv */
// shared types, sizes and codes for the sorted key table
`default_nettype none
package skt_pkg;

  localparam int CAPACITY     = 128;
  localparam int KEY_BITS     = 16;
  localparam int VALUE_BITS   = 32;
  localparam int IDX_BITS     = $clog2(CAPACITY);
  localparam int CNT_BITS     = $clog2(CAPACITY + 1);
  localparam int CMD_BITS     = 2;
  localparam int STATUS_BITS  = 3;
  localparam int SLOT_BITS    = 7;
  localparam int ENTRIES_BITS = 8;

  typedef logic [KEY_BITS-1:0]     key_t;
  typedef logic [VALUE_BITS-1:0]   value_t;
  typedef logic [IDX_BITS-1:0]     idx_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [CMD_BITS-1:0]     cmd_t;
  typedef logic [STATUS_BITS-1:0]  status_t;
  typedef logic [SLOT_BITS-1:0]    slot_t;
  typedef logic [ENTRIES_BITS-1:0] entries_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_SEARCH = 2'd2;

  localparam status_t STATUS_OK        = 3'd0;
  localparam status_t STATUS_DUPLICATE = 3'd1;
  localparam status_t STATUS_FULL      = 3'd2;
  localparam status_t STATUS_NOT_FOUND = 3'd3;
  localparam status_t STATUS_EMPTY     = 3'd4;

  typedef struct packed {
    key_t   key;
    value_t value;
  } entry_t;

  // one read and one write port per cycle
  typedef struct packed {
    logic   we;
    idx_t   wr_addr;
    entry_t wr_data;
    idx_t   rd_addr;
  } mem_req_t;

endpackage
`default_nettype wire

/* hw/rtl/skt_if.sv */
// request and response channel interfaces of the sorted key table
`default_nettype none
interface skt_req_if;
  logic            valid;
  logic            ready;
  skt_pkg::cmd_t   command;
  skt_pkg::key_t   key;
  skt_pkg::value_t entry_value;

  modport source (output valid, output command, output key, output entry_value,
                  input ready);
  modport sink (input valid, input command, input key, input entry_value,
                output ready);
endinterface

interface skt_rsp_if;
  logic              valid;
  logic              ready;
  skt_pkg::status_t  status;
  skt_pkg::slot_t    slot;
  skt_pkg::value_t   found_value;
  skt_pkg::entries_t entries;

  modport source (output valid, output status, output slot, output found_value,
                  output entries, input ready);
  modport sink (input valid, input status, input slot, input found_value,
                input entries, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sorted_key_table.sv */
// sorted key table top level: sequencer, binary search and shift over the entry memory
//
// Holds up to CAPACITY unique keys with a value each, in ascending key order, in one
// single-port-read, single-port-write memory. Each request is taken when the block is
// idle and runs to completion before the next one: each binary search probe first reads
// the memory, then compares the key read back; a successful insert then moves every
// later entry up, and a successful remove moves every later entry down, one entry per
// cycle through the memory port. A full table (insert), an empty table (remove, search)
// and an unused command skip the search and go straight to the response. The response
// is held in an output register, so a new request can be taken while the previous
// response waits; a further response waits until that one has been taken.
`default_nettype none
module sorted_key_table (
  input wire         clk,
  input wire         rst,
  skt_req_if.sink    req,
  skt_rsp_if.source  rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_PROBE  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_UP     = 3'd4;
  localparam logic [2:0] S_DOWN   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;

  skt_pkg::cnt_t    count;
  skt_pkg::cmd_t    cmd;
  skt_pkg::key_t    key;
  skt_pkg::value_t  value;
  skt_pkg::cnt_t    lo;
  skt_pkg::cnt_t    hi;
  skt_pkg::idx_t    mid;
  skt_pkg::cnt_t    pos;
  skt_pkg::cnt_t    j;
  logic             pend;
  skt_pkg::idx_t    wa;

  skt_pkg::status_t res_status;
  skt_pkg::cnt_t    res_slot;
  skt_pkg::value_t  res_found;

  logic              out_valid;
  skt_pkg::status_t  out_status;
  skt_pkg::slot_t    out_slot;
  skt_pkg::value_t   out_found;
  skt_pkg::entries_t out_entries;

  skt_pkg::mem_req_t mem_req;
  skt_pkg::entry_t   rd_data;

  logic [skt_pkg::CNT_BITS:0] mid_sum;
  skt_pkg::idx_t              mid_calc;
  skt_pkg::cnt_t              j_dec;
  logic [skt_pkg::CNT_BITS:0] j_inc;

  skt_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[skt_pkg::IDX_BITS:1];
  assign j_dec    = j - skt_pkg::cnt_t'(1);
  assign j_inc    = {1'b0, j} + (skt_pkg::CNT_BITS + 1)'(1);

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.slot        = out_slot;
  assign rsp.found_value = out_found;
  assign rsp.entries     = out_entries;

  // memory port steering
  always_comb begin
    mem_req         = '0;
    mem_req.wr_data = rd_data;
    mem_req.rd_addr = mid_calc;
    case (state)
      S_SEARCH: begin
        if (lo >= hi) begin
          mem_req.rd_addr = lo[skt_pkg::IDX_BITS-1:0];
        end
      end
      S_UP: begin
        mem_req.rd_addr = j_dec[skt_pkg::IDX_BITS-1:0];
        if (pend) begin
          mem_req.we      = 1'b1;
          mem_req.wr_addr = wa;
        end else if (j == pos) begin
          // last step drops the new entry into the gap
          mem_req.we            = 1'b1;
          mem_req.wr_addr       = pos[skt_pkg::IDX_BITS-1:0];
          mem_req.wr_data.key   = key;
          mem_req.wr_data.value = value;
        end
      end
      S_DOWN: begin
        mem_req.rd_addr = j_inc[skt_pkg::IDX_BITS-1:0];
        if (pend) begin
          mem_req.we      = 1'b1;
          mem_req.wr_addr = wa;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // in S_FINISH the output register is refilled instead
      if (out_valid && rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd        <= req.command;
            key        <= req.key;
            value      <= req.entry_value;
            res_slot   <= '0;
            res_found  <= '0;
            lo         <= '0;
            hi         <= count;
            case (req.command)
              skt_pkg::CMD_INSERT: begin
                if (count >= skt_pkg::cnt_t'(skt_pkg::CAPACITY)) begin
                  res_status <= skt_pkg::STATUS_FULL;
                  state      <= S_FINISH;
                end else begin
                  res_status <= skt_pkg::STATUS_OK;
                  state      <= S_SEARCH;
                end
              end
              skt_pkg::CMD_REMOVE, skt_pkg::CMD_SEARCH: begin
                if (count == '0) begin
                  res_status <= skt_pkg::STATUS_EMPTY;
                  state      <= S_FINISH;
                end else begin
                  res_status <= skt_pkg::STATUS_OK;
                  state      <= S_SEARCH;
                end
              end
              default: begin
                res_status <= skt_pkg::STATUS_OK;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            mid   <= mid_calc;
            state <= S_PROBE;
          end else begin
            pos <= lo;
            if (lo < count) begin
              state <= S_CHECK;
            end else if (cmd == skt_pkg::CMD_INSERT) begin
              // append at the end, nothing to move
              j     <= count;
              pend  <= 1'b0;
              state <= S_UP;
            end else begin
              res_status <= skt_pkg::STATUS_NOT_FOUND;
              state      <= S_FINISH;
            end
          end
        end
        S_PROBE: begin
          if (rd_data.key < key) begin
            lo <= skt_pkg::cnt_t'(mid) + skt_pkg::cnt_t'(1);
          end else begin
            hi <= skt_pkg::cnt_t'(mid);
          end
          state <= S_SEARCH;
        end
        S_CHECK: begin
          case (cmd)
            skt_pkg::CMD_INSERT: begin
              if (rd_data.key == key) begin
                res_status <= skt_pkg::STATUS_DUPLICATE;
                res_slot   <= pos;
                state      <= S_FINISH;
              end else begin
                j     <= count;
                pend  <= 1'b0;
                state <= S_UP;
              end
            end
            skt_pkg::CMD_SEARCH: begin
              if (rd_data.key == key) begin
                res_slot  <= pos;
                res_found <= rd_data.value;
              end else begin
                res_status <= skt_pkg::STATUS_NOT_FOUND;
              end
              state <= S_FINISH;
            end
            default: begin
              if (rd_data.key == key) begin
                res_slot <= pos;
                j        <= pos;
                pend     <= 1'b0;
                state    <= S_DOWN;
              end else begin
                res_status <= skt_pkg::STATUS_NOT_FOUND;
                state      <= S_FINISH;
              end
            end
          endcase
        end
        S_UP: begin
          // read slot j-1 now, write it to slot j next cycle
          if (j > pos) begin
            wa   <= j[skt_pkg::IDX_BITS-1:0];
            j    <= j_dec;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count    <= count + skt_pkg::cnt_t'(1);
              res_slot <= pos;
              state    <= S_FINISH;
            end
          end
        end
        S_DOWN: begin
          // read slot j+1 now, write it to slot j next cycle
          if (j_inc < {1'b0, count}) begin
            wa   <= j[skt_pkg::IDX_BITS-1:0];
            j    <= j_inc[skt_pkg::CNT_BITS-1:0];
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - skt_pkg::cnt_t'(1);
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_slot    <= skt_pkg::slot_t'(res_slot);
            out_found   <= res_found;
            out_entries <= skt_pkg::entries_t'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/skt_store.sv */
// entry memory: keys and values, one write and one registered read per cycle
`default_nettype none
module skt_store (
  input  wire               clk,
  input  skt_pkg::mem_req_t mem_req,
  output skt_pkg::entry_t   rd_data
);

  skt_pkg::entry_t mem [skt_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    rd_data <= mem[mem_req.rd_addr];
  end

endmodule
`default_nettype wire

/* tb/sv/skt_table_monitor.sv */
// monitor, predictor and response comparison for the sorted key table channels
`timescale 1ns / 1ps
module skt_table_monitor (
  input  logic clk,
  input  logic rst,
  skt_req_if   req,
  skt_rsp_if   rsp,
  output int   mismatch_count,
  output int   pending_count
);
  import skt_pkg::*;

  typedef struct packed {
    status_t  status;
    slot_t    slot;
    value_t   found_value;
    entries_t entries;
  } table_rsp_t;

  key_t       stored_keys [CAPACITY];
  value_t     stored_values [CAPACITY];
  int         stored_count = 0;
  int         errors = 0;
  table_rsp_t expected_rsps [$];

  function automatic table_rsp_t apply_to_table(cmd_t cmd, key_t key, value_t value);
    table_rsp_t r;
    int lo;
    int hi;
    int mid;
    r = '0;
    lo = 0;
    hi = stored_count;
    // first slot whose key is not smaller
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (stored_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    case (cmd)
      CMD_INSERT: begin
        if (stored_count >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (lo < stored_count && stored_keys[lo] == key) begin
          r.status = STATUS_DUPLICATE;
          r.slot = slot_t'(lo);
        end else begin
          for (int j = stored_count; j > lo; j--) begin
            stored_keys[j] = stored_keys[j-1];
            stored_values[j] = stored_values[j-1];
          end
          stored_keys[lo] = key;
          stored_values[lo] = value;
          stored_count++;
          r.slot = slot_t'(lo);
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (stored_count == 0) begin
          r.status = STATUS_EMPTY;
        end else if (lo >= stored_count || stored_keys[lo] != key) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.slot = slot_t'(lo);
          if (cmd == CMD_SEARCH) begin
            r.found_value = stored_values[lo];
          end else begin
            for (int j = lo; j + 1 < stored_count; j++) begin
              stored_keys[j] = stored_keys[j+1];
              stored_values[j] = stored_values[j+1];
            end
            stored_count--;
          end
        end
      end
      default: ;
    endcase
    r.entries = entries_t'(stored_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_rsp_t want;
    if (rst) begin
      stored_count = 0;
      expected_rsps.delete();
    end else begin
      // a response always belongs to an earlier request, so retire before predicting
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t unexpected response: status=%0d slot=%0d found=%h entries=%0d",
                   $time, rsp.status, rsp.slot, rsp.found_value, rsp.entries);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status || rsp.slot !== want.slot ||
              rsp.found_value !== want.found_value || rsp.entries !== want.entries) begin
            $display("%0t mismatch: expected status=%0d slot=%0d found=%h entries=%0d",
                     $time, want.status, want.slot, want.found_value, want.entries);
            $display("%0t            actual status=%0d slot=%0d found=%h entries=%0d",
                     $time, rsp.status, rsp.slot, rsp.found_value, rsp.entries);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_rsps.push_back(apply_to_table(req.command, req.key, req.entry_value));
    end
    pending_count <= expected_rsps.size();
    mismatch_count <= errors;
  end

endmodule

/* tb/sv/tb.sv */
// top of the sorted key table testbench: clock, reset, request and response traffic, verdict
`timescale 1ns / 1ps
module tb;
  import skt_pkg::*;

  localparam cmd_t CMD_UNUSED     = 2'd3;
  localparam int   POOL_SIZE      = 192;
  localparam int   ITEMS_PER_MODE = 400;
  localparam int   GROW_ITEMS     = 250;
  localparam int   HOLD_CYCLES    = 2000;
  localparam int   DRAIN_CYCLES   = 200;
  localparam int   CYCLE_LIMIT    = 1000000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles = 0;

  int   send_idle_pct = 20;
  int   recv_idle_pct = 56;
  int   hold_requests = 0;
  int   holds_done = 0;
  int   hold_left = 0;

  key_t pool_keys [POOL_SIZE];
  bit   in_table [POOL_SIZE];
  int   table_fill = 0;

  skt_req_if req_ch ();
  skt_rsp_if rsp_ch ();

  sorted_key_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  skt_table_monitor u_monitor (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (fail_count),
    .pending_count  (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL sorted_key_table");
      $finish;
    end
  end

  // response side: random stalls, plus a long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input key_t key, input value_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.key <= key;
    req_ch.entry_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    // pending is a registered copy of the queue size, so look only from the next edge on
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly hits on a pool of keys so the table grows to full and shrinks back
  task automatic send_random(input bit growing);
    int     r;
    int     idx;
    int     tries;
    cmd_t   cmd;
    key_t   key;
    value_t value;
    r = $urandom_range(99);
    if (growing)
      cmd = (r < 70) ? CMD_INSERT : (r < 82) ? CMD_REMOVE : (r < 97) ? CMD_SEARCH : CMD_UNUSED;
    else
      cmd = (r < 15) ? CMD_INSERT : (r < 75) ? CMD_REMOVE : (r < 97) ? CMD_SEARCH : CMD_UNUSED;
    value = $urandom;
    case ($urandom_range(15))
      0: value = '0;
      1: value = '1;
      default: ;
    endcase
    idx = $urandom_range(POOL_SIZE - 1);
    tries = 0;
    if (cmd == CMD_INSERT) begin
      if ($urandom_range(6) != 0)
        while (in_table[idx] && tries < 8) begin
          idx = $urandom_range(POOL_SIZE - 1);
          tries++;
        end
    end else if ($urandom_range(3) != 0) begin
      while (!in_table[idx] && tries < 8) begin
        idx = $urandom_range(POOL_SIZE - 1);
        tries++;
      end
    end
    key = pool_keys[idx];
    if ($urandom_range(19) == 0) begin
      key = key_t'($urandom);
      idx = -1;
    end
    case (cmd)
      CMD_INSERT: begin
        if (idx >= 0 && !in_table[idx] && table_fill < CAPACITY) begin
          in_table[idx] = 1'b1;
          table_fill++;
        end
      end
      CMD_REMOVE: begin
        if (idx >= 0 && in_table[idx]) begin
          in_table[idx] = 1'b0;
          table_fill--;
        end
      end
      default: ;
    endcase
    send_item(cmd, key, value);
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.command <= CMD_INSERT;
    req_ch.key <= '0;
    req_ch.entry_value <= '0;
    pool_keys[0] = '0;
    pool_keys[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool_keys[i] = key_t'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) in_table[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused code, ends of the key range, duplicates, misses
    send_item(CMD_SEARCH, 16'h1234, 32'h0);
    send_item(CMD_REMOVE, 16'h1234, 32'hffffffff);
    send_item(CMD_UNUSED, 16'h0000, 32'h0);
    send_item(CMD_INSERT, 16'h8000, 32'h12345678);
    send_item(CMD_INSERT, 16'h0000, 32'h00000000);
    send_item(CMD_INSERT, 16'hffff, 32'hffffffff);
    send_item(CMD_INSERT, 16'h8000, 32'h00000001);
    send_item(CMD_INSERT, 16'h0000, 32'hdeadbeef);
    send_item(CMD_SEARCH, 16'hffff, 32'h0);
    send_item(CMD_SEARCH, 16'h0000, 32'h0);
    send_item(CMD_SEARCH, 16'h7fff, 32'h0);
    send_item(CMD_SEARCH, 16'hfffe, 32'h0);
    send_item(CMD_REMOVE, 16'h0001, 32'h0);
    send_item(CMD_UNUSED, 16'hffff, 32'hffffffff);
    send_item(CMD_INSERT, 16'h4000, 32'haaaaaaaa);
    send_item(CMD_INSERT, 16'hc000, 32'h55555555);
    send_item(CMD_REMOVE, 16'h0000, 32'h0);
    send_item(CMD_REMOVE, 16'hffff, 32'h0);
    send_item(CMD_SEARCH, 16'h8000, 32'h0);
    send_item(CMD_REMOVE, 16'h8000, 32'h0);
    send_item(CMD_REMOVE, 16'h4000, 32'h0);
    send_item(CMD_REMOVE, 16'hc000, 32'h0);
    send_item(CMD_SEARCH, 16'h8000, 32'h0);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // long response stall while requests keep coming, so the input backs up
      if (mode == 0) hold_requests++;
      for (int n = 0; n < ITEMS_PER_MODE; n++) send_random(n < GROW_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS sorted_key_table");
    end else begin
      $display("FAIL sorted_key_table");
    end
    $finish;
  end

endmodule
